// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the splitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define CHECK_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define CHECK_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mss_pkg.sv
// Types, character codes and mode tables for the marked source splitter.
package mss_pkg;

   localparam int CP_BITS     = 21;
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 3;
   localparam int NUM_DELIMS  = 15;

   typedef enum logic [3:0] {
      MODE_EXP_HDR = 4'd0,
      MODE_EXP_SRC = 4'd1,
      MODE_IN_HDR  = 4'd2,
      MODE_IN_SRC  = 4'd3,
      MODE_INH     = 4'd4,
      MODE_ANY     = 4'd5,
      MODE_HPP     = 4'd6,
      MODE_CPP     = 4'd7,
      MODE_FUNC    = 4'd8,
      MODE_MEMBER  = 4'd9
   } mode_type;

   // result kinds
   localparam logic [4:0] K_ECHO       = 5'd0;
   localparam logic [4:0] K_HPP        = 5'd1;
   localparam logic [4:0] K_CPP        = 5'd2;
   localparam logic [4:0] K_BOTH       = 5'd3;
   localparam logic [4:0] K_INHERIT    = 5'd4;
   localparam logic [4:0] K_HDR_NAME   = 5'd5;
   localparam logic [4:0] K_SRC_NAME   = 5'd6;
   localparam logic [4:0] K_HDR_END    = 5'd7;
   localparam logic [4:0] K_SRC_END    = 5'd8;
   localparam logic [4:0] K_MEMBER     = 5'd9;
   localparam logic [4:0] K_MEMBER_END = 5'd10;
   localparam logic [4:0] K_INS_INH    = 5'd11;
   localparam logic [4:0] K_INS_SCOPE  = 5'd12;
   localparam logic [4:0] K_INS_BOTH   = 5'd13;
   localparam logic [4:0] K_INS_HPP    = 5'd14;
   localparam logic [4:0] K_INS_CPP    = 5'd15;
   localparam logic [4:0] K_ERROR      = 5'd16;

   // error codes
   localparam logic [1:0] E_UNEXPECTED  = 2'd0;
   localparam logic [1:0] E_NEEDLESS    = 2'd1;
   localparam logic [1:0] E_NOT_ALLOWED = 2'd2;
   localparam logic [1:0] E_ESC_AT_END  = 2'd3;

   // special characters
   localparam logic [20:0] CH_NEWLINE = 21'h00000A;
   localparam logic [20:0] CH_SEMI    = 21'h00003B;
   localparam logic [20:0] CH_LBRACE  = 21'h00007B;
   localparam logic [20:0] CH_RBRACE  = 21'h00007D;
   localparam logic [20:0] CH_ESC     = 21'h00013C;
   localparam logic [20:0] CH_LP      = 21'h00276A;
   localparam logic [20:0] CH_RP      = 21'h00276B;
   localparam logic [20:0] CH_SRC     = 21'h0026AF;
   localparam logic [20:0] CH_IHO     = 21'h00269E;
   localparam logic [20:0] CH_IHC     = 21'h00269F;
   localparam logic [20:0] CH_SUN     = 21'h002600;
   localparam logic [20:0] CH_DIA     = 21'h0025C8;
   localparam logic [20:0] CH_HO      = 21'h0025C0;
   localparam logic [20:0] CH_HC      = 21'h0025B6;
   localparam logic [20:0] CH_CO      = 21'h0025D6;
   localparam logic [20:0] CH_CC      = 21'h0025D7;
   localparam logic [20:0] CH_FO      = 21'h002770;
   localparam logic [20:0] CH_FC      = 21'h002771;
   localparam logic [20:0] CH_DM      = 21'h001360;

   typedef logic [NUM_DELIMS-1:0] delim_mask_type;

   localparam logic [20:0] DELIM_CHARS [NUM_DELIMS] = '{
      CH_ESC, CH_LP, CH_RP, CH_SRC, CH_IHO, CH_IHC, CH_SUN, CH_DIA,
      CH_HO, CH_HC, CH_CO, CH_CC, CH_FO, CH_FC, CH_DM
   };

   // everything but the data member mark may follow an escape
   localparam delim_mask_type ESCAPABLE = 15'h3FFF;

   typedef struct packed {
      mode_type mode;
      logic     escape_pending;
      logic     halted;
   } state_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [20:0] character;
      logic [1:0]  error_code;
      logic        last;
   } slot_type;

   typedef struct packed {
      slot_type [MAX_RESULTS-1:0] slot;
      logic [1:0]                 count;
   } burst_type;

   // delimiters forbidden in each mode; unused mode codes forbid all
   function automatic delim_mask_type forbidden_mask(input mode_type mode);
      delim_mask_type mask;
      case (mode)
         MODE_EXP_HDR: mask = 15'h3FF4;
         MODE_EXP_SRC: mask = 15'h3FEC;
         MODE_IN_HDR:  mask = 15'h3FFA;
         MODE_IN_SRC:  mask = 15'h3FFA;
         MODE_INH:     mask = 15'h3F5E;
         MODE_ANY:     mask = 15'h2A3E;
         MODE_HPP:     mask = 15'h3D7E;
         MODE_CPP:     mask = 15'h377E;
         MODE_FUNC:    mask = 15'h1FFE;
         MODE_MEMBER:  mask = 15'h3FFE;
         default:      mask = '1;
      endcase
      return mask;
   endfunction

endpackage

// File: hw/rtl/mss_step_decode.sv
// Per-character mode step: next state and up to three tagged results.
module mss_step_decode (
   input  mss_pkg::state_type   state_now,
   input  logic [20:0]          code_point,
   input  logic                 end_of_input,
   output mss_pkg::state_type   state_next,
   output mss_pkg::burst_type   burst
);
   import mss_pkg::*;

   delim_mask_type dbit;
   logic           forb;
   logic           emit_echo;
   logic           emit_a;
   logic           emit_b;
   logic [4:0]     a_kind;
   logic [20:0]    a_char;
   logic [1:0]     a_err;
   logic [4:0]     b_kind;
   logic [20:0]    b_char;
   logic           do_fail;
   logic [1:0]     n;

   always_comb begin
      for (int i = 0; i < NUM_DELIMS; i++) begin
         dbit[i] = (code_point == DELIM_CHARS[i]);
      end
   end

   assign forb = |(forbidden_mask(state_now.mode) & dbit);

   always_comb begin
      state_next = state_now;
      emit_echo  = 1'b0;
      emit_a     = 1'b0;
      emit_b     = 1'b0;
      a_kind     = K_ECHO;
      a_char     = '0;
      a_err      = E_UNEXPECTED;
      b_kind     = K_ECHO;
      b_char     = '0;
      do_fail    = 1'b0;

      if (!state_now.halted) begin
         if (end_of_input) begin
            if (state_now.escape_pending) begin
               do_fail = 1'b1;
               a_err   = E_ESC_AT_END;
            end
         end else begin
            emit_echo = (state_now.mode >= MODE_INH) && (state_now.mode <= MODE_MEMBER);
            if (state_now.escape_pending) begin
               state_next.escape_pending = 1'b0;
               if ((dbit & ESCAPABLE) == '0) begin
                  do_fail = 1'b1;
                  a_err   = E_NEEDLESS;
               end else begin
                  a_char = code_point;
                  case (state_now.mode)
                     MODE_ANY: begin
                        emit_a = 1'b1;
                        a_kind = K_BOTH;
                     end
                     MODE_HPP: begin
                        emit_a = 1'b1;
                        a_kind = K_HPP;
                     end
                     MODE_CPP, MODE_FUNC: begin
                        emit_a = 1'b1;
                        a_kind = K_CPP;
                     end
                     default: begin
                        do_fail = 1'b1;
                        a_err   = E_NOT_ALLOWED;
                     end
                  endcase
               end
            end else if (code_point == CH_ESC) begin
               state_next.escape_pending = 1'b1;
            end else begin
               a_char = code_point;
               case (state_now.mode)
                  MODE_EXP_HDR: begin
                     if (code_point == CH_LP) state_next.mode = MODE_IN_HDR;
                     else if (code_point == CH_SRC) state_next.mode = MODE_EXP_SRC;
                     else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_BOTH;
                     end
                  end
                  MODE_EXP_SRC: begin
                     if (code_point == CH_LP) state_next.mode = MODE_IN_SRC;
                     else if (code_point == CH_IHO) state_next.mode = MODE_INH;
                     else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_BOTH;
                     end
                  end
                  MODE_IN_HDR: begin
                     if (code_point == CH_RP) begin
                        state_next.mode = MODE_EXP_HDR;
                        emit_a          = 1'b1;
                        a_kind          = K_HDR_END;
                        a_char          = '0;
                     end else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_HDR_NAME;
                     end
                  end
                  MODE_IN_SRC: begin
                     if (code_point == CH_RP) begin
                        state_next.mode = MODE_EXP_SRC;
                        emit_a          = 1'b1;
                        a_kind          = K_SRC_END;
                        a_char          = '0;
                     end else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_SRC_NAME;
                     end
                  end
                  MODE_INH: begin
                     if (code_point == CH_IHC) state_next.mode = MODE_ANY;
                     else if (code_point == CH_DIA) begin
                        emit_a = 1'b1;
                        a_kind = K_INS_INH;
                        a_char = '0;
                     end else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_INHERIT;
                     end
                  end
                  MODE_ANY: begin
                     if (code_point == CH_HO) state_next.mode = MODE_HPP;
                     else if (code_point == CH_CO) state_next.mode = MODE_CPP;
                     else if (code_point == CH_SUN) begin
                        emit_a = 1'b1;
                        a_kind = K_INS_SCOPE;
                        a_char = '0;
                     end else if (code_point == CH_DIA) begin
                        emit_a = 1'b1;
                        a_kind = K_INS_BOTH;
                        a_char = '0;
                     end else if (code_point == CH_FO) begin
                        state_next.mode = MODE_FUNC;
                        emit_a          = 1'b1;
                        a_kind          = K_HPP;
                        a_char          = CH_SEMI;
                        emit_b          = 1'b1;
                        b_kind          = K_CPP;
                        b_char          = CH_LBRACE;
                     end else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_BOTH;
                     end
                  end
                  MODE_HPP: begin
                     if (code_point == CH_HC) state_next.mode = MODE_ANY;
                     else if (code_point == CH_DIA) begin
                        emit_a = 1'b1;
                        a_kind = K_INS_HPP;
                        a_char = '0;
                     end else if (code_point == CH_DM) state_next.mode = MODE_MEMBER;
                     else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_HPP;
                     end
                  end
                  MODE_CPP: begin
                     if (code_point == CH_CC) state_next.mode = MODE_ANY;
                     else if (code_point == CH_DIA) begin
                        emit_a = 1'b1;
                        a_kind = K_INS_CPP;
                        a_char = '0;
                     end else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_CPP;
                     end
                  end
                  MODE_FUNC: begin
                     if (code_point == CH_FC) begin
                        state_next.mode = MODE_ANY;
                        emit_a          = 1'b1;
                        a_kind          = K_CPP;
                        a_char          = CH_RBRACE;
                     end else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_CPP;
                     end
                  end
                  MODE_MEMBER: begin
                     if (code_point == CH_DM) begin
                        state_next.mode = MODE_HPP;
                        emit_a          = 1'b1;
                        a_kind          = K_MEMBER_END;
                        a_char          = '0;
                     end else if (forb) do_fail = 1'b1;
                     else begin
                        emit_a = 1'b1;
                        a_kind = K_MEMBER;
                     end
                  end
                  default: do_fail = 1'b1;
               endcase
            end
         end
      end

      // a failure replaces any first result with the error, drops any second one and halts
      if (do_fail) begin
         state_next.halted         = 1'b1;
         state_next.escape_pending = 1'b0;
         emit_a                    = 1'b1;
         emit_b                    = 1'b0;
         a_kind                    = K_ERROR;
         a_char                    = '0;
      end else begin
         a_err = E_UNEXPECTED;
      end
   end

   // pack echo, first and second result in order, last flag on the final one
   always_comb begin
      burst = '0;
      n     = '0;
      if (emit_echo) begin
         burst.slot[n] = '{kind: K_ECHO, character: code_point,
                           error_code: E_UNEXPECTED, last: 1'b0};
         n = n + 2'd1;
      end
      if (emit_a) begin
         burst.slot[n] = '{kind: a_kind, character: a_char, error_code: a_err, last: 1'b0};
         n = n + 2'd1;
      end
      if (emit_b) begin
         burst.slot[n] = '{kind: b_kind, character: b_char,
                           error_code: E_UNEXPECTED, last: 1'b0};
         n = n + 2'd1;
      end
      if (n != 2'd0) begin
         burst.slot[n - 2'd1].last = 1'b1;
      end
      burst.count = n;
   end

endmodule

// File: hw/rtl/mss_result_queue.sv
// Result queue: takes up to three results a cycle, hands out one per ready cycle.
`include "assert_macros.svh"

module mss_result_queue #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mss_pkg::burst_type     push_burst,
   input  logic                   push_en,
   input  logic [LINE_BITS-1:0]   push_line,
   input  logic [COLUMN_BITS-1:0] push_column,
   output logic                   space_ok,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mss_pkg::slot_type      out_slot,
   output logic [LINE_BITS-1:0]   out_line,
   output logic [COLUMN_BITS-1:0] out_column
);
   import mss_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   slot_type               slot_ff   [QUEUE_DEPTH];
   logic [LINE_BITS-1:0]   line_ff   [QUEUE_DEPTH];
   logic [COLUMN_BITS-1:0] column_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ff, wr_in;
   logic [PTR_BITS-1:0]    rd_ff, rd_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    push_n;
   logic                   pop;

   assign push_n    = push_en ? CNT_BITS'(push_burst.count) : '0;
   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign space_ok  = (count_ff <= CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));
   assign out_slot   = slot_ff[rd_ff];
   assign out_line   = line_ff[rd_ff];
   assign out_column = column_ff[rd_ff];

   assign wr_in    = wr_ff + PTR_BITS'(push_n);
   assign rd_in    = rd_ff + PTR_BITS'(pop);
   assign count_in = count_ff + push_n - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (CNT_BITS'(i) < push_n) begin
            slot_ff[wr_ff + PTR_BITS'(i)]   <= push_burst.slot[i];
            line_ff[wr_ff + PTR_BITS'(i)]   <= push_line;
            column_ff[wr_ff + PTR_BITS'(i)] <= push_column;
         end
      end
   end

   `CHECK_ALWAYS(a_count_bound, count_ff <= CNT_BITS'(QUEUE_DEPTH), "queue count beyond depth")
   `CHECK_SAME(a_no_overflow, push_n != '0, (count_ff + push_n) <= CNT_BITS'(QUEUE_DEPTH), "queue overflow")
   `CHECK_NEXT(a_pop_moves, pop && push_n == '0, count_ff == $past(count_ff) - 1'b1, "pop lost")

endmodule

// File: hw/rtl/marked_source_splitter.sv
// Top level of the marked source splitter: state, position counters and ports.
//
// One Unicode code point enters per request on the req_ side; end of file is
// flagged by req_tlast, and its code point is ignored. Each character is
// steered by the current mode and answered with zero to three tagged results
// on the rsp_ side (echo, header, source, both, inheritance, include name,
// member name, name insertion marker or error), the last result of a request
// marked by rsp_tlast. Every result carries the line and column after the
// request's own update; both counters saturate. A forbidden delimiter or a
// bad escape gives a single error result and the block then swallows all
// further requests without answer until reset. The mode step is one level of
// logic between the state registers and a four-entry result queue, so a
// request is taken in the cycle it arrives whenever the queue holds at most
// one result; the response port drains one result per clock while rsp_tready
// is high, so the sustained rate is one request per cycle while each gives at
// most one result, and a request giving more (three at worst, the opening of a
// function body in a mode that echoes) holds off the next until the queue drains.
// In modes that echo, an error result follows the echo. No reset sweep.
`include "assert_macros.svh"

module marked_source_splitter #(
   parameter int  LINE_BITS   = 20,
   parameter int  COLUMN_BITS = 16,
   localparam int RSP_BITS    = ((28 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,  // [20:0] code_point, rest zero
   input  logic                req_tlast,  // end_of_input
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,  // kind, character, error_code,
                                           // line_at, column_at, zero fill
   output logic                rsp_tlast   // last_of_run
);
   import mss_pkg::*;

   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

   state_type              state_ff, state_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   burst_type              burst;
   logic                   accept;
   logic                   advance;
   logic [20:0]            code_point;
   slot_type               out_slot;
   logic [LINE_BITS-1:0]   out_line;
   logic [COLUMN_BITS-1:0] out_column;

   assign code_point = req_tdata[20:0];
   assign accept     = req_tvalid && req_tready;
   // position moves on every real character while running
   assign advance    = accept && !state_ff.halted && !req_tlast;

   always_comb begin
      line_in   = line_ff;
      column_in = column_ff;
      if (advance) begin
         if (code_point == CH_NEWLINE) begin
            if (!(&line_ff)) line_in = line_ff + LINE_ONE;
            column_in = '0;
         end else if (!(&column_ff)) begin
            column_in = column_ff + COL_ONE;
         end
      end
   end

   mss_step_decode u_step (
      .state_now    (state_ff),
      .code_point   (code_point),
      .end_of_input (req_tlast),
      .state_next   (state_in),
      .burst        (burst)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '{mode: MODE_EXP_HDR, escape_pending: 1'b0, halted: 1'b0};
         line_ff   <= LINE_ONE;
         column_ff <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         line_ff   <= line_in;
         column_ff <= column_in;
      end
   end

   mss_result_queue #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_burst  (burst),
      .push_en     (accept),
      .push_line   (line_in),
      .push_column (column_in),
      .space_ok    (req_tready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_slot    (out_slot),
      .out_line    (out_line),
      .out_column  (out_column)
   );

   assign rsp_tdata = RSP_BITS'({out_column, out_line, out_slot.error_code,
                                 out_slot.character, out_slot.kind});
   assign rsp_tlast = out_slot.last;

   `CHECK_SAME(a_halted_silent, accept && state_ff.halted, burst.count == 2'd0, "result while halted")
   `CHECK_NEXT(a_halt_on_request, !state_ff.halted && !accept, !state_ff.halted, "halt without request")
   `CHECK_NEXT(a_eof_keeps_position, accept && req_tlast, $stable(line_ff) && $stable(column_ff), "position moved at end of file")
   `CHECK_ALWAYS(a_halt_clears_escape, !(state_ff.halted && state_ff.escape_pending), "escape pending while halted")

endmodule
